@@ sv/zcf_pkg.sv @@
`timescale 1ns / 1ps
// Shared widths and register codes for the zero-crossing frequency core.
// No dependencies; the interfaces, the core and zcf_mul use it, zcf_div does not.
package zcf_pkg;

   localparam int CALIB_W    = 16;
   localparam int RATE_W     = 24;
   localparam int HYST_W     = 8;
   localparam int FREQ_W     = 32;
   localparam int RISE_W     = 32;
   localparam int FRAC_W     = 8;
   localparam int PROD_W     = RISE_W + RATE_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = RATE_W;

   localparam logic [CSR_IDX_W-1:0] CSR_CALIB_COUNT  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_RATE  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HYST_DIVISOR = 2'd2;

   localparam logic [CALIB_W-1:0] CALIB_RESET = 16'd1024;
   localparam logic [RATE_W-1:0]  RATE_RESET  = 24'd48000;
   localparam logic [HYST_W-1:0]  HYST_RESET  = 8'd10;

   localparam logic [0:0] REQ_SAMPLE  = 1'b0;
   localparam logic [0:0] REQ_RESTART = 1'b1;

endpackage

@@ sv/zcf_if.sv @@
`timescale 1ns / 1ps
// Request and result channel interfaces of the zero-crossing frequency core.
// Depends on zcf_pkg for the result field widths.
interface zcf_req_if #(parameter int SAMPLE_BITS = 24);
   logic                          valid;
   logic                          ready;
   logic                          req_type;
   logic signed [SAMPLE_BITS-1:0] sample;

   modport source (output valid, req_type, sample, input ready);
   modport sink   (input valid, req_type, sample, output ready);
endinterface

interface zcf_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [zcf_pkg::FREQ_W-1:0]  frequency_q8;
   logic                        has_result;
   logic [zcf_pkg::RISE_W-1:0]  rise_total;
   logic                        calibrating;

   modport source (output valid, frequency_q8, has_result, rise_total, calibrating,
                   input ready);
   modport sink   (input valid, frequency_q8, has_result, rise_total, calibrating,
                   output ready);
endinterface

@@ sv/stream_zero_crossing_frequency_core.sv @@
`timescale 1ns / 1ps
// Zero-crossing frequency counter with hysteresis band, digit-serial datapath.
// Depends on zcf_pkg, zcf_if (channel interfaces), zcf_div and zcf_mul.
//
// Usage:
//   req_ch carries one item: a sample (req_type 0) or a restart (req_type 1).
//   rsp_ch returns exactly one result per item, in order.
//   csr_we/csr_index/csr_wdata write calib_count (0), sample_rate (1) and
//   hyst_divisor (2); write them only while no item is in flight.
// Sequencing:
//   One item is worked on at a time; req_ch.ready is high only when the
//   sequencer is idle. A restart, or a sample while no rise has been counted,
//   goes to the result without the serial units. With rises counted the result
//   needs the serial multiply and then the serial divide; the divide is skipped
//   when the quotient would saturate. The sample that closes calibration also
//   runs the mean divide and the band divide first. The shared divider works
//   one quotient bit per cycle.
// Reset and stall:
//   reset restores the register defaults and clears all measurement state.
//   A finished result waits in the output register while rsp_ch.ready is low;
//   the next item is still accepted and held at its end until the slot frees.
module stream_zero_crossing_frequency_core #(
   parameter int SAMPLE_BITS = 24,
   parameter int INDEX_BITS  = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [zcf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [zcf_pkg::CSR_DATA_W-1:0]   csr_wdata,
   zcf_req_if.sink                          req_ch,
   zcf_rsp_if.source                        rsp_ch
);
   import zcf_pkg::*;

   localparam int SUM_W  = SAMPLE_BITS + CALIB_W;   // sum of up to 65535 samples
   localparam int MAG_W  = SUM_W + 1;               // rounded sum magnitude
   localparam int SPAN_W = SAMPLE_BITS + 1;
   localparam int BAND_W = SAMPLE_BITS + 2;
   localparam int QW     = (MAG_W > FREQ_W) ? MAG_W : FREQ_W;
   localparam int DEN_W  = (INDEX_BITS > CALIB_W) ? INDEX_BITS : CALIB_W;
   localparam int CNT_W  = $clog2(QW + 1);
   localparam int LO_W   = PROD_W - FREQ_W;         // product bits below the top word

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_UPDATE    = 4'd1;
   localparam logic [3:0] ST_MEAN      = 4'd2;
   localparam logic [3:0] ST_MEAN_WAIT = 4'd3;
   localparam logic [3:0] ST_HALF      = 4'd4;
   localparam logic [3:0] ST_HALF_WAIT = 4'd5;
   localparam logic [3:0] ST_FREQ      = 4'd6;
   localparam logic [3:0] ST_MUL_WAIT  = 4'd7;
   localparam logic [3:0] ST_FDIV_WAIT = 4'd8;
   localparam logic [3:0] ST_DONE      = 4'd9;

   localparam logic [INDEX_BITS-1:0] IDX_MAX = {INDEX_BITS{1'b1}};
   localparam logic [RISE_W-1:0]     RISE_MAX = {RISE_W{1'b1}};

   // configuration
   logic [CALIB_W-1:0] calib_ff, calib_in;
   logic [RATE_W-1:0]  rate_ff, rate_in;
   logic [HYST_W-1:0]  hyst_ff, hyst_in;

   // sequencer and captured item
   logic [3:0]                    state_ff, state_in;
   logic                          restart_ff, restart_in;
   logic signed [SAMPLE_BITS-1:0] y_ff, y_in;

   // measurement state
   logic [INDEX_BITS-1:0]         idx_ff, idx_in;
   logic signed [SUM_W-1:0]       sum_ff, sum_in;
   logic signed [SAMPLE_BITS-1:0] min_ff, min_in;
   logic signed [SAMPLE_BITS-1:0] max_ff, max_in;
   logic signed [SAMPLE_BITS-1:0] mean_ff, mean_in;
   logic signed [BAND_W-1:0]      blo_ff, blo_in;
   logic signed [BAND_W-1:0]      bhi_ff, bhi_in;
   logic [INDEX_BITS-1:0]         first_ff, first_in;
   logic                          first_seen_ff, first_seen_in;
   logic [INDEX_BITS-1:0]         last_ff, last_in;
   logic [RISE_W-1:0]             rise_ff, rise_in;
   logic                          pol_known_ff, pol_known_in;
   logic                          last_above_ff, last_above_in;
   logic [FREQ_W-1:0]             freq_ff, freq_in;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [FREQ_W-1:0]             rsp_freq_ff, rsp_freq_in;
   logic                          rsp_has_ff, rsp_has_in;
   logic [RISE_W-1:0]             rsp_rise_ff, rsp_rise_in;
   logic                          rsp_cal_ff, rsp_cal_in;

   // serial units
   logic              div_start;
   logic [CNT_W-1:0]  div_steps;
   logic [DEN_W-1:0]  div_rem;
   logic [QW-1:0]     div_dividend;
   logic [DEN_W-1:0]  div_den;
   logic              div_done;
   logic [QW-1:0]     div_quot;
   logic              mul_start;
   logic              mul_done;
   logic [PROD_W-1:0] mul_prod;

   // datapath helpers
   logic [INDEX_BITS-1:0]         calib_ext;
   logic                          in_calib;
   logic                          calib_last;
   logic signed [SAMPLE_BITS-1:0] min_pick, max_pick;
   logic signed [BAND_W-1:0]      y_band;
   logic                          above, in_band;
   logic [MAG_W-1:0]              mean_num, mean_mag;
   logic                          mean_neg;
   logic [SAMPLE_BITS-1:0]        mean_q;
   logic [SPAN_W-1:0]             span, half;
   logic [HYST_W-1:0]             hyst_eff;
   logic [INDEX_BITS-1:0]         period;
   logic [FREQ_W-1:0]             num_hi;
   logic [FREQ_W-1:0]             num_lo;
   logic                          freq_sat;
   logic                          rsp_free;

   zcf_div #(.QUOT_W(QW), .DEN_W(DEN_W), .CNT_W(CNT_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .steps    (div_steps),
      .rem_init (div_rem),
      .dividend (div_dividend),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quot)
   );

   zcf_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mcand   (rise_ff),
      .mplier  (rate_ff),
      .done    (mul_done),
      .product (mul_prod)
   );

   // calibration bookkeeping
   assign calib_ext  = INDEX_BITS'(calib_ff);
   assign in_calib   = idx_ff < calib_ext;
   assign calib_last = (idx_ff + INDEX_BITS'(1)) == calib_ext;
   assign min_pick   = (idx_ff == '0 || y_ff < min_ff) ? y_ff : min_ff;
   assign max_pick   = (idx_ff == '0 || y_ff > max_ff) ? y_ff : max_ff;

   // crossing test against the band and the mean
   assign y_band  = BAND_W'(y_ff);
   assign above   = y_ff > mean_ff;
   assign in_band = (y_band > blo_ff) && (y_band < bhi_ff);

   // rounded mean: trunc((sum + n/2) / n), sign handled around the divide
   assign mean_num = MAG_W'(sum_ff) + MAG_W'(calib_ff[CALIB_W-1:1]);
   assign mean_neg = mean_num[MAG_W-1];
   assign mean_mag = mean_neg ? (~mean_num + MAG_W'(1)) : mean_num;
   assign mean_q   = div_quot[SAMPLE_BITS-1:0];

   assign span     = SPAN_W'(max_ff) - SPAN_W'(min_ff);
   assign half     = div_quot[SPAN_W-1:0];
   assign hyst_eff = (hyst_ff == '0) ? HYST_W'(1) : hyst_ff;

   // frequency: rise*rate*256 / period, the top word decides saturation
   assign period   = last_ff - first_ff;
   assign num_hi   = mul_prod[PROD_W-1:LO_W];
   assign num_lo   = {mul_prod[LO_W-1:0], {FRAC_W{1'b0}}};
   assign freq_sat = num_hi >= FREQ_W'(period);

   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;

   // operand selection for the shared divider, and the multiplier start
   always_comb begin
      div_start    = 1'b0;
      div_steps    = CNT_W'(MAG_W);
      div_rem      = '0;
      div_dividend = QW'(mean_mag) << (QW - MAG_W);
      div_den      = DEN_W'(calib_ff);
      mul_start    = 1'b0;
      unique case (state_ff)
         ST_MEAN: begin
            div_start = 1'b1;
         end
         ST_HALF: begin
            div_start    = 1'b1;
            div_steps    = CNT_W'(SPAN_W);
            div_dividend = QW'(span) << (QW - SPAN_W);
            div_den      = DEN_W'(hyst_eff);
         end
         ST_MUL_WAIT: begin
            div_start    = mul_done && !freq_sat;
            div_steps    = CNT_W'(FREQ_W);
            div_rem      = DEN_W'(num_hi);
            div_dividend = QW'(num_lo) << (QW - FREQ_W);
            div_den      = DEN_W'(period);
         end
         ST_FREQ: begin
            mul_start = rise_ff != '0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      calib_in      = calib_ff;
      rate_in       = rate_ff;
      hyst_in       = hyst_ff;
      state_in      = state_ff;
      restart_in    = restart_ff;
      y_in          = y_ff;
      idx_in        = idx_ff;
      sum_in        = sum_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      mean_in       = mean_ff;
      blo_in        = blo_ff;
      bhi_in        = bhi_ff;
      first_in      = first_ff;
      first_seen_in = first_seen_ff;
      last_in       = last_ff;
      rise_in       = rise_ff;
      pol_known_in  = pol_known_ff;
      last_above_in = last_above_ff;
      freq_in       = freq_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_freq_in   = rsp_freq_ff;
      rsp_has_in    = rsp_has_ff;
      rsp_rise_in   = rsp_rise_ff;
      rsp_cal_in    = rsp_cal_ff;

      // register writes; indexes past the list are dropped
      if (csr_we) begin
         unique case (csr_index)
            CSR_CALIB_COUNT:  calib_in = csr_wdata[CALIB_W-1:0];
            CSR_SAMPLE_RATE:  rate_in  = csr_wdata[RATE_W-1:0];
            CSR_HYST_DIVISOR: hyst_in  = csr_wdata[HYST_W-1:0];
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               restart_in = req_ch.req_type == REQ_RESTART;
               y_in       = req_ch.sample;
               state_in   = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = ST_FREQ;
            if (restart_ff) begin
               // clear all measurement state
               idx_in        = '0;
               sum_in        = '0;
               min_in        = '0;
               max_in        = '0;
               mean_in       = '0;
               blo_in        = '0;
               bhi_in        = '0;
               first_in      = '0;
               first_seen_in = 1'b0;
               last_in       = '0;
               rise_in       = '0;
               pol_known_in  = 1'b0;
               last_above_in = 1'b0;
            end else begin
               if (in_calib) begin
                  sum_in = sum_ff + SUM_W'(y_ff);
                  min_in = min_pick;
                  max_in = max_pick;
                  if (calib_last) begin
                     state_in = ST_MEAN;
                  end
               end else if (!in_band) begin
                  if (!pol_known_ff) begin
                     pol_known_in  = 1'b1;
                     last_above_in = above;
                  end else if (last_above_ff != above) begin
                     if (above) begin
                        if (!first_seen_ff) begin
                           first_seen_in = 1'b1;
                           first_in      = idx_ff;
                        end else begin
                           last_in = idx_ff;
                           if (rise_ff != RISE_MAX) begin
                              rise_in = rise_ff + RISE_W'(1);
                           end
                        end
                     end
                     last_above_in = above;
                  end
               end
               // advance the index, holding at the top
               if (idx_ff != IDX_MAX) begin
                  idx_in = idx_ff + INDEX_BITS'(1);
               end
            end
         end
         ST_MEAN: begin
            state_in = ST_MEAN_WAIT;
         end
         ST_MEAN_WAIT: begin
            if (div_done) begin
               mean_in  = mean_neg ? $signed(~mean_q + SAMPLE_BITS'(1)) : $signed(mean_q);
               state_in = ST_HALF;
            end
         end
         ST_HALF: begin
            state_in = ST_HALF_WAIT;
         end
         ST_HALF_WAIT: begin
            if (div_done) begin
               blo_in   = BAND_W'(mean_ff) - $signed(BAND_W'(half));
               bhi_in   = BAND_W'(mean_ff) + $signed(BAND_W'(half));
               state_in = ST_FREQ;
            end
         end
         ST_FREQ: begin
            if (rise_ff == '0) begin
               freq_in  = '0;
               state_in = ST_DONE;
            end else begin
               state_in = ST_MUL_WAIT;
            end
         end
         ST_MUL_WAIT: begin
            if (mul_done) begin
               if (freq_sat) begin
                  freq_in  = {FREQ_W{1'b1}};
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_FDIV_WAIT;
               end
            end
         end
         ST_FDIV_WAIT: begin
            if (div_done) begin
               freq_in  = div_quot[FREQ_W-1:0];
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold the result until the output slot is free
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_freq_in  = freq_ff;
               rsp_has_in   = rise_ff != '0;
               rsp_rise_in  = rise_ff;
               rsp_cal_in   = in_calib;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         calib_ff      <= CALIB_RESET;
         rate_ff       <= RATE_RESET;
         hyst_ff       <= HYST_RESET;
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         idx_ff        <= '0;
         sum_ff        <= '0;
         min_ff        <= '0;
         max_ff        <= '0;
         mean_ff       <= '0;
         blo_ff        <= '0;
         bhi_ff        <= '0;
         first_ff      <= '0;
         first_seen_ff <= 1'b0;
         last_ff       <= '0;
         rise_ff       <= '0;
         pol_known_ff  <= 1'b0;
         last_above_ff <= 1'b0;
      end else begin
         calib_ff      <= calib_in;
         rate_ff       <= rate_in;
         hyst_ff       <= hyst_in;
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         idx_ff        <= idx_in;
         sum_ff        <= sum_in;
         min_ff        <= min_in;
         max_ff        <= max_in;
         mean_ff       <= mean_in;
         blo_ff        <= blo_in;
         bhi_ff        <= bhi_in;
         first_ff      <= first_in;
         first_seen_ff <= first_seen_in;
         last_ff       <= last_in;
         rise_ff       <= rise_in;
         pol_known_ff  <= pol_known_in;
         last_above_ff <= last_above_in;
      end
      restart_ff  <= restart_in;
      y_ff        <= y_in;
      freq_ff     <= freq_in;
      rsp_freq_ff <= rsp_freq_in;
      rsp_has_ff  <= rsp_has_in;
      rsp_rise_ff <= rsp_rise_in;
      rsp_cal_ff  <= rsp_cal_in;
   end

   assign req_ch.ready        = state_ff == ST_IDLE;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.frequency_q8 = rsp_freq_ff;
   assign rsp_ch.has_result   = rsp_has_ff;
   assign rsp_ch.rise_total   = rsp_rise_ff;
   assign rsp_ch.calibrating  = rsp_cal_ff;

endmodule

@@ sv/zcf_div.sv @@
`timescale 1ns / 1ps
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on nothing but its parameters; zcf_pkg is not needed.
module zcf_div #(
   parameter int QUOT_W = 49,
   parameter int DEN_W  = 32,
   parameter int CNT_W  = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [CNT_W-1:0]  steps,
   input  logic [DEN_W-1:0]  rem_init,
   input  logic [QUOT_W-1:0] dividend,
   input  logic [DEN_W-1:0]  divisor,
   output logic              done,
   output logic [QUOT_W-1:0] quotient
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [QUOT_W-1:0] quo_ff, quo_in;

   logic [DEN_W:0]    shifted;
   logic [DEN_W+1:0]  diff;
   logic              borrow;

   // dividend is left-aligned; its MSB shifts into the partial remainder
   assign shifted = {rem_ff, quo_ff[QUOT_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, den_ff};
   assign borrow  = diff[DEN_W+1];

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = steps;
         rem_in  = rem_init;
         den_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = borrow ? shifted[DEN_W-1:0] : diff[DEN_W-1:0];
         quo_in = {quo_ff[QUOT_W-2:0], ~borrow};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ sv/zcf_mul.sv @@
`timescale 1ns / 1ps
// Bit-serial shift-add multiplier: rise count times sample rate.
// Depends on zcf_pkg for operand and product widths.
module zcf_mul (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [zcf_pkg::RISE_W-1:0]   mcand,
   input  logic [zcf_pkg::RATE_W-1:0]   mplier,
   output logic                         done,
   output logic [zcf_pkg::PROD_W-1:0]   product
);
   import zcf_pkg::*;

   localparam int CNT_W = $clog2(RATE_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [RISE_W-1:0] mcand_ff, mcand_in;
   logic [PROD_W-1:0] acc_ff, acc_in;
   logic [RISE_W:0]   upper;

   // add the multiplicand into the top when the next multiplier bit is set
   assign upper = {1'b0, acc_ff[PROD_W-1:RATE_W]} +
                  {1'b0, (acc_ff[0] ? mcand_ff : {RISE_W{1'b0}})};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      mcand_in = mcand_ff;
      acc_in   = acc_ff;
      if (start && !busy_ff) begin
         busy_in  = 1'b1;
         cnt_in   = CNT_W'(RATE_W);
         mcand_in = mcand;
         acc_in   = {{RISE_W{1'b0}}, mplier};
      end else if (busy_ff) begin
         acc_in = {upper, acc_ff[RATE_W-1:1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mcand_ff <= mcand_in;
      acc_ff   <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule
